/* sv/nsl_pkg.sv */
// Shared types and constants for the nearest speaker channel lock block.
// Used by nsl_ctrl, nsl_dp and nearest_speaker_channel_lock; no dependencies.
package nsl_pkg;

	// field widths fixed by the interface
	localparam int POS_W      = 16;
	localparam int IDX_OUT_W  = 6;
	localparam int MASK_W     = 64;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 40;
	localparam int CNT_REG_W  = 7;

	// squared distance in unit 2^-32, and the tie-break key
	localparam int SQ_W   = 33;
	localparam int DIST_W = 44;
	localparam int KEY_W  = 64;

	// action codes
	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LOCK_ENABLE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_MODE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_ENABLE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST_SQ   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPEAKER_COUNT = 3'd4;

	// distance modes
	localparam logic MODE_POLAR = 1'b0;

	// controller states, one-hot
	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_DRAIN  = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;    // write the beat into the tables
		logic start;   // latch query source and mask, clear best
		logic issue;   // read one table entry into the scan pipe
		logic finish;  // load the output register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic pipe_busy;  // scan pipe still holds entries
		logic out_free;   // output register can take a result
	} sts_t;

endpackage

/* sv/nearest_speaker_channel_lock.sv */
// Top level of the nearest speaker channel lock: configuration registers,
// controller and datapath. Depends on nsl_pkg, nsl_ctrl and nsl_dp.

// A load beat writes one speaker entry and does not stall the input. A query
// beat scans entries 0 to min(speaker_count, MAX_SPEAKERS)-1, one entry per
// cycle through the single read port of the speaker tables, then drains a
// three-stage distance pipe; the input stays stalled until the result is in the
// output register. A query with the lock off or a count of zero skips the scan.
// The result sits in an output register, so the next beat is accepted while it
// waits to be taken. Table entries are undefined until loaded; the user must write
// configuration only while the block is idle, which the block does not enforce.
module nearest_speaker_channel_lock #(
	parameter int MAX_SPEAKERS = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// input channel
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 action,
	input  logic [nsl_pkg::IDX_OUT_W-1:0]        entry_index,
	input  logic signed [nsl_pkg::POS_W-1:0]     pos_x,
	input  logic signed [nsl_pkg::POS_W-1:0]     pos_y,
	input  logic signed [nsl_pkg::POS_W-1:0]     pos_z,
	input  logic signed [nsl_pkg::POS_W-1:0]     azimuth,
	input  logic signed [nsl_pkg::POS_W-1:0]     elevation,
	input  logic signed [nsl_pkg::POS_W-1:0]     lock_x,
	input  logic signed [nsl_pkg::POS_W-1:0]     lock_y,
	input  logic signed [nsl_pkg::POS_W-1:0]     lock_z,
	input  logic [nsl_pkg::MASK_W-1:0]           excluded_mask,
	// output channel
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [nsl_pkg::POS_W-1:0]     result_x,
	output logic signed [nsl_pkg::POS_W-1:0]     result_y,
	output logic signed [nsl_pkg::POS_W-1:0]     result_z,
	output logic                                 did_lock,
	output logic [nsl_pkg::IDX_OUT_W-1:0]        chosen_speaker,
	// configuration write channel
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [nsl_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [nsl_pkg::CFG_DATA_W-1:0]       cfg_data
);

	localparam int IDX_W = (MAX_SPEAKERS > 1) ? $clog2(MAX_SPEAKERS) : 1;
	localparam int CNT_W = $clog2(MAX_SPEAKERS + 1);

	// configuration registers
	logic                              lock_enable_q;
	logic                              distance_mode_q;
	logic                              limit_enable_q;
	logic [nsl_pkg::CFG_DATA_W-1:0]    max_dist_sq_q;
	logic [nsl_pkg::CNT_REG_W-1:0]     speaker_count_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lock_enable_q   <= 1'b0;
			distance_mode_q <= 1'b0;
			limit_enable_q  <= 1'b0;
			max_dist_sq_q   <= '0;
			speaker_count_q <= nsl_pkg::CNT_REG_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				nsl_pkg::REG_LOCK_ENABLE:   lock_enable_q   <= cfg_data[0];
				nsl_pkg::REG_DISTANCE_MODE: distance_mode_q <= cfg_data[0];
				nsl_pkg::REG_LIMIT_ENABLE:  limit_enable_q  <= cfg_data[0];
				nsl_pkg::REG_MAX_DIST_SQ:   max_dist_sq_q   <= cfg_data;
				nsl_pkg::REG_SPEAKER_COUNT:
					speaker_count_q <= cfg_data[nsl_pkg::CNT_REG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// entries scanned per query, clamped to the table depth
	logic [CNT_W-1:0] scan_count;
	assign scan_count = (speaker_count_q > nsl_pkg::CNT_REG_W'(MAX_SPEAKERS))
		? CNT_W'(MAX_SPEAKERS) : CNT_W'(speaker_count_q);

	nsl_pkg::cmd_t    cmd;
	nsl_pkg::sts_t    sts;
	logic [IDX_W-1:0] rd_addr;

	nsl_ctrl #(
		.IDX_W (IDX_W),
		.CNT_W (CNT_W)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.action      (action),
		.lock_enable (lock_enable_q),
		.scan_count  (scan_count),
		.sts         (sts),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.rd_addr     (rd_addr)
	);

	nsl_dp #(
		.MAX_SPEAKERS (MAX_SPEAKERS),
		.IDX_W        (IDX_W)
	) u_dp (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cmd                  (cmd),
		.rd_addr              (rd_addr),
		.sts                  (sts),
		.distance_mode        (distance_mode_q),
		.limit_enable         (limit_enable_q),
		.max_distance_squared (max_dist_sq_q),
		.entry_index          (entry_index),
		.pos_x                (pos_x),
		.pos_y                (pos_y),
		.pos_z                (pos_z),
		.azimuth              (azimuth),
		.elevation            (elevation),
		.lock_x               (lock_x),
		.lock_y               (lock_y),
		.lock_z               (lock_z),
		.excluded_mask        (excluded_mask),
		.out_valid            (out_valid),
		.out_stall            (out_stall),
		.result_x             (result_x),
		.result_y             (result_y),
		.result_z             (result_z),
		.did_lock             (did_lock),
		.chosen_speaker       (chosen_speaker)
	);

endmodule

/* sv/nsl_ctrl.sv */
// Controller for the speaker lock: accepts beats, sequences the table scan.
// Depends on nsl_pkg.
module nsl_ctrl #(
	parameter int IDX_W = 5,
	parameter int CNT_W = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                action,
	input  logic                lock_enable,
	input  logic [CNT_W-1:0]    scan_count,
	input  nsl_pkg::sts_t       sts,
	output logic                in_stall,
	output nsl_pkg::cmd_t       cmd,
	output logic [IDX_W-1:0]    rd_addr
);

	nsl_pkg::state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             accept;
	logic             last;

	assign in_stall = (state_q != nsl_pkg::ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign last     = (CNT_W'(cnt_q + 1'b1) == scan_count);
	assign rd_addr  = cnt_q[IDX_W-1:0];

	// next state and commands
	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		cmd        = '0;
		unique case (state_q)
			nsl_pkg::ST_IDLE: begin
				if (accept) begin
					if (action == nsl_pkg::ACT_LOAD) begin
						cmd.load = 1'b1;
					end else begin
						cmd.start = 1'b1;
						cnt_d     = '0;
						if (lock_enable && (scan_count != '0))
							state_d = nsl_pkg::ST_SCAN;
						else
							state_d = nsl_pkg::ST_FINISH;
					end
				end
			end
			nsl_pkg::ST_SCAN: begin
				cmd.issue = 1'b1;
				if (last)
					state_d = nsl_pkg::ST_DRAIN;
				else
					cnt_d = CNT_W'(cnt_q + 1'b1);
			end
			nsl_pkg::ST_DRAIN: begin
				if (!sts.pipe_busy)
					state_d = nsl_pkg::ST_FINISH;
			end
			nsl_pkg::ST_FINISH: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = nsl_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = nsl_pkg::ST_IDLE;
			end
		endcase
	end

	// state and scan counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nsl_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

/* sv/nsl_dp.sv */
// Datapath for the speaker lock: speaker tables, distance pipe, running best
// and output register. Depends on nsl_pkg.
module nsl_dp #(
	parameter int MAX_SPEAKERS = 32,
	parameter int IDX_W        = 5
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  nsl_pkg::cmd_t                        cmd,
	input  logic [IDX_W-1:0]                     rd_addr,
	output nsl_pkg::sts_t                        sts,
	// configuration
	input  logic                                 distance_mode,
	input  logic                                 limit_enable,
	input  logic [nsl_pkg::CFG_DATA_W-1:0]       max_distance_squared,
	// input beat
	input  logic [nsl_pkg::IDX_OUT_W-1:0]        entry_index,
	input  logic signed [nsl_pkg::POS_W-1:0]     pos_x,
	input  logic signed [nsl_pkg::POS_W-1:0]     pos_y,
	input  logic signed [nsl_pkg::POS_W-1:0]     pos_z,
	input  logic signed [nsl_pkg::POS_W-1:0]     azimuth,
	input  logic signed [nsl_pkg::POS_W-1:0]     elevation,
	input  logic signed [nsl_pkg::POS_W-1:0]     lock_x,
	input  logic signed [nsl_pkg::POS_W-1:0]     lock_y,
	input  logic signed [nsl_pkg::POS_W-1:0]     lock_z,
	input  logic [nsl_pkg::MASK_W-1:0]           excluded_mask,
	// result beat
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [nsl_pkg::POS_W-1:0]     result_x,
	output logic signed [nsl_pkg::POS_W-1:0]     result_y,
	output logic signed [nsl_pkg::POS_W-1:0]     result_z,
	output logic                                 did_lock,
	output logic [nsl_pkg::IDX_OUT_W-1:0]        chosen_speaker
);

	localparam int P3 = 3 * nsl_pkg::POS_W;
	localparam int P2 = 2 * nsl_pkg::POS_W;
	localparam int PW = nsl_pkg::POS_W;

	// tables
	logic [P3-1:0] pos_mem  [MAX_SPEAKERS];
	logic [P2-1:0] ang_mem  [MAX_SPEAKERS];
	logic [P3-1:0] lock_mem [MAX_SPEAKERS];

	logic wr_en;
	assign wr_en = cmd.load &&
		({1'b0, entry_index} < (nsl_pkg::IDX_OUT_W + 1)'(MAX_SPEAKERS));

	// query latches
	logic signed [PW-1:0]        src_x_q, src_y_q, src_z_q;
	logic [nsl_pkg::MASK_W-1:0]  mask_q;

	// pipe stages
	logic                        v_s1, v_s2, v_s3;
	logic [P3-1:0]               pos_s1, lock_s1, lock_s2, lock_s3;
	logic [P2-1:0]               ang_s1;
	logic [IDX_W-1:0]            idx_s1, idx_s2, idx_s3;
	logic [nsl_pkg::SQ_W-1:0]    sqx_s2, sqy_s2, sqz_s2;
	logic [nsl_pkg::KEY_W-1:0]   key_s2, key_s3;
	logic [nsl_pkg::DIST_W-1:0]  d_s3;

	// running best
	logic                        found_q;
	logic [nsl_pkg::DIST_W-1:0]  best_d_q;
	logic [nsl_pkg::KEY_W-1:0]   best_key_q;
	logic [IDX_W-1:0]            best_idx_q;
	logic [P3-1:0]               best_lock_q;

	logic                        out_valid_q;

	// table write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			pos_mem[entry_index[IDX_W-1:0]]  <= {pos_x, pos_y, pos_z};
			ang_mem[entry_index[IDX_W-1:0]]  <= {azimuth, elevation};
			lock_mem[entry_index[IDX_W-1:0]] <= {lock_x, lock_y, lock_z};
		end
		pos_s1  <= pos_mem[rd_addr];
		ang_s1  <= ang_mem[rd_addr];
		lock_s1 <= lock_mem[rd_addr];
	end

	// stage 2: coordinate differences squared, tie-break key
	logic signed [PW:0]      dx, dy, dz;
	logic signed [2*PW+1:0]  px, py, pz;
	logic [PW-1:0]           az, el, abs_az, abs_el;

	assign dx = {pos_s1[P3-1], pos_s1[P3-1 -: PW]} - {src_x_q[PW-1], src_x_q};
	assign dy = {pos_s1[P2-1], pos_s1[P2-1 -: PW]} - {src_y_q[PW-1], src_y_q};
	assign dz = {pos_s1[PW-1], pos_s1[PW-1:0]}     - {src_z_q[PW-1], src_z_q};
	assign px = dx * dx;
	assign py = dy * dy;
	assign pz = dz * dz;

	assign az     = ang_s1[P2-1 -: PW];
	assign el     = ang_s1[PW-1:0];
	assign abs_az = az[PW-1] ? PW'(~az + 1'b1) : az;
	assign abs_el = el[PW-1] ? PW'(~el + 1'b1) : el;

	// stage 3: weighted sum
	logic [nsl_pkg::DIST_W-1:0] d_sum;
	always_comb begin
		if (distance_mode == nsl_pkg::MODE_POLAR)
			d_sum = (nsl_pkg::DIST_W'(sqx_s2) + nsl_pkg::DIST_W'(sqy_s2)
				+ nsl_pkg::DIST_W'(sqz_s2)) << 4;
		else
			d_sum = nsl_pkg::DIST_W'(sqx_s2) + (nsl_pkg::DIST_W'(sqy_s2) << 6)
				+ (nsl_pkg::DIST_W'(sqz_s2) << 9);
	end

	logic [nsl_pkg::DIST_W-1:0] limit;
	logic                       in_limit;
	assign limit    = {max_distance_squared, 4'b0000};
	assign in_limit = !limit_enable || (d_sum < limit);

	// best update: distance first, then key; earlier entry keeps an exact tie
	logic better;
	assign better = v_s3 && (!found_q || ({d_s3, key_s3} < {best_d_q, best_key_q}));

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= cmd.issue && !mask_q[rd_addr];
			v_s2 <= v_s1;
			v_s3 <= v_s2 && in_limit;
			if (cmd.start)
				found_q <= 1'b0;
			else if (better)
				found_q <= 1'b1;
			if (cmd.finish)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			src_x_q <= pos_x;
			src_y_q <= pos_y;
			src_z_q <= pos_z;
			mask_q  <= excluded_mask;
		end
		idx_s1  <= rd_addr;
		idx_s2  <= idx_s1;
		lock_s2 <= lock_s1;
		sqx_s2  <= px[nsl_pkg::SQ_W-1:0];
		sqy_s2  <= py[nsl_pkg::SQ_W-1:0];
		sqz_s2  <= pz[nsl_pkg::SQ_W-1:0];
		key_s2  <= {abs_az, ~az[PW-1], az[PW-2:0], abs_el, ~el[PW-1], el[PW-2:0]};
		idx_s3  <= idx_s2;
		lock_s3 <= lock_s2;
		key_s3  <= key_s2;
		d_s3    <= d_sum;
		if (better) begin
			best_d_q    <= d_s3;
			best_key_q  <= key_s3;
			best_idx_q  <= idx_s3;
			best_lock_q <= lock_s3;
		end
		if (cmd.finish) begin
			if (found_q) begin
				result_x       <= best_lock_q[P3-1 -: PW];
				result_y       <= best_lock_q[P2-1 -: PW];
				result_z       <= best_lock_q[PW-1:0];
				chosen_speaker <= nsl_pkg::IDX_OUT_W'(best_idx_q);
			end else begin
				result_x       <= src_x_q;
				result_y       <= src_y_q;
				result_z       <= src_z_q;
				chosen_speaker <= '0;
			end
			did_lock <= found_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign sts.pipe_busy = v_s1 || v_s2 || v_s3;
	assign sts.out_free  = !out_valid_q || !out_stall;

endmodule

/* test/nsl_lock_checker.sv */
// Result checker for nearest_speaker_channel_lock: keeps its own speaker tables and
// register copies, predicts each query result and compares it with the output beats.
// Depends on nsl_pkg; instantiated beside the block by tb_nearest_speaker_channel_lock.
module nsl_lock_checker #(
	parameter int SPEAKERS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// input channel
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic                                action,
	input  logic [nsl_pkg::IDX_OUT_W-1:0]       entry_index,
	input  logic signed [nsl_pkg::POS_W-1:0]    pos_x,
	input  logic signed [nsl_pkg::POS_W-1:0]    pos_y,
	input  logic signed [nsl_pkg::POS_W-1:0]    pos_z,
	input  logic signed [nsl_pkg::POS_W-1:0]    azimuth,
	input  logic signed [nsl_pkg::POS_W-1:0]    elevation,
	input  logic signed [nsl_pkg::POS_W-1:0]    lock_x,
	input  logic signed [nsl_pkg::POS_W-1:0]    lock_y,
	input  logic signed [nsl_pkg::POS_W-1:0]    lock_z,
	input  logic [nsl_pkg::MASK_W-1:0]          excluded_mask,
	// output channel
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic signed [nsl_pkg::POS_W-1:0]    result_x,
	input  logic signed [nsl_pkg::POS_W-1:0]    result_y,
	input  logic signed [nsl_pkg::POS_W-1:0]    result_z,
	input  logic                                did_lock,
	input  logic [nsl_pkg::IDX_OUT_W-1:0]       chosen_speaker,
	// configuration write channel
	input  logic                                cfg_valid,
	input  logic                                cfg_ready,
	input  logic [nsl_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [nsl_pkg::CFG_DATA_W-1:0]      cfg_data,
	// to the testbench top
	output int                                  errors,
	output int                                  waiting
);

	localparam int REPORT_MAX = 10;

	typedef logic signed [nsl_pkg::POS_W-1:0] coord_t;

	typedef struct packed {
		coord_t                          x;
		coord_t                          y;
		coord_t                          z;
		logic                            locked;
		logic [nsl_pkg::IDX_OUT_W-1:0]   speaker;
	} lock_result_t;

	// register copies
	logic                            lock_on;
	logic                            dist_mode;
	logic                            limit_on;
	logic [nsl_pkg::CFG_DATA_W-1:0]  max_dist_sq;
	logic [nsl_pkg::CNT_REG_W-1:0]   speaker_count;

	// speaker tables
	coord_t spk_x [SPEAKERS];
	coord_t spk_y [SPEAKERS];
	coord_t spk_z [SPEAKERS];
	coord_t spk_az [SPEAKERS];
	coord_t spk_el [SPEAKERS];
	coord_t lock_px [SPEAKERS];
	coord_t lock_py [SPEAKERS];
	coord_t lock_pz [SPEAKERS];

	lock_result_t lock_results_q [$];
	lock_result_t pred;
	lock_result_t want;
	lock_result_t got;

	function automatic int mag(int v);
		return (v < 0) ? -v : v;
	endfunction

	// tie-break order on (|az|, az, |el|, el)
	function automatic bit angle_precedes(int a1, int e1, int a2, int e2);
		if (mag(a1) != mag(a2))
			return mag(a1) < mag(a2);
		if (a1 != a2)
			return a1 < a2;
		if (mag(e1) != mag(e2))
			return mag(e1) < mag(e2);
		return e1 < e2;
	endfunction

	function automatic logic [63:0] squared_gap(coord_t a, coord_t b);
		longint d;
		d = longint'(a) - longint'(b);
		return d * d;
	endfunction

	// scan the table for the closest admissible speaker, exact compare in 2^-32 units
	function automatic lock_result_t nearest_speaker(coord_t qx, coord_t qy, coord_t qz,
			logic [nsl_pkg::MASK_W-1:0] mask);
		lock_result_t res;
		logic [63:0]  sq_dist;
		logic [63:0]  best_dist;
		logic [63:0]  limit;
		logic [63:0]  gx, gy, gz;
		int           scan;
		int           best;
		int           i;
		bit           found;
		found = 0;
		best = 0;
		best_dist = '0;
		limit = {24'd0, max_dist_sq} << 4;
		scan = (int'(speaker_count) < SPEAKERS) ? int'(speaker_count) : SPEAKERS;
		if (lock_on) begin
			for (i = 0; i < scan; i++) begin
				if (!mask[i]) begin
					gx = squared_gap(spk_x[i], qx);
					gy = squared_gap(spk_y[i], qy);
					gz = squared_gap(spk_z[i], qz);
					if (dist_mode == nsl_pkg::MODE_POLAR)
						sq_dist = (gx + gy + gz) << 4;
					else
						sq_dist = gx + (gy << 6) + (gz << 9);
					if (!(limit_on && sq_dist >= limit)) begin
						if (!found || sq_dist < best_dist || (sq_dist == best_dist &&
								angle_precedes(spk_az[i], spk_el[i],
									spk_az[best], spk_el[best]))) begin
							found = 1;
							best = i;
							best_dist = sq_dist;
						end
					end
				end
			end
		end
		res.x = found ? lock_px[best] : qx;
		res.y = found ? lock_py[best] : qy;
		res.z = found ? lock_pz[best] : qz;
		res.locked = found;
		res.speaker = found ? nsl_pkg::IDX_OUT_W'(best) : '0;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lock_on = 1'b0;
			dist_mode = nsl_pkg::MODE_POLAR;
			limit_on = 1'b0;
			max_dist_sq = '0;
			speaker_count = nsl_pkg::CNT_REG_W'(1);
			lock_results_q.delete();
			errors = 0;
			waiting = 0;
		end else begin
			// result beat against the oldest prediction
			if (out_valid && !out_stall) begin
				got.x = result_x;
				got.y = result_y;
				got.z = result_z;
				got.locked = did_lock;
				got.speaker = chosen_speaker;
				if (lock_results_q.size() == 0) begin
					errors++;
					if (errors <= REPORT_MAX)
						$display({"mismatch: unexpected result beat ",
							"x=%0d y=%0d z=%0d lock=%0b spk=%0d"},
							got.x, got.y, got.z, got.locked, got.speaker);
				end else begin
					want = lock_results_q.pop_front();
					if (got !== want) begin
						errors++;
						if (errors <= REPORT_MAX)
							$display({"mismatch: expected ",
								"x=%0d y=%0d z=%0d lock=%0b spk=%0d, ",
								"got x=%0d y=%0d z=%0d lock=%0b spk=%0d"},
								want.x, want.y, want.z, want.locked, want.speaker,
								got.x, got.y, got.z, got.locked, got.speaker);
					end
				end
			end

			// input beat: a query predicts, a load updates the tables
			if (in_valid && !in_stall) begin
				if (action == nsl_pkg::ACT_QUERY) begin
					pred = nearest_speaker(pos_x, pos_y, pos_z, excluded_mask);
					lock_results_q = {lock_results_q, pred};
				end else if (entry_index < SPEAKERS) begin
					spk_x[entry_index] = pos_x;
					spk_y[entry_index] = pos_y;
					spk_z[entry_index] = pos_z;
					spk_az[entry_index] = azimuth;
					spk_el[entry_index] = elevation;
					lock_px[entry_index] = lock_x;
					lock_py[entry_index] = lock_y;
					lock_pz[entry_index] = lock_z;
				end
			end

			// register write
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					nsl_pkg::REG_LOCK_ENABLE:   lock_on = cfg_data[0];
					nsl_pkg::REG_DISTANCE_MODE: dist_mode = cfg_data[0];
					nsl_pkg::REG_LIMIT_ENABLE:  limit_on = cfg_data[0];
					nsl_pkg::REG_MAX_DIST_SQ:   max_dist_sq = cfg_data;
					nsl_pkg::REG_SPEAKER_COUNT:
						speaker_count = cfg_data[nsl_pkg::CNT_REG_W-1:0];
					default: ;
				endcase
			end

			waiting = lock_results_q.size();
		end
	end

endmodule

/* test/tb_nearest_speaker_channel_lock.sv */
// Testbench top for nearest_speaker_channel_lock: clock, reset, directed and random
// beats with random gaps and stalls, configuration phases, and the final verdict.
// Depends on nsl_pkg, nearest_speaker_channel_lock and nsl_lock_checker.
module tb_nearest_speaker_channel_lock;

	localparam int SPEAKERS      = 32;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int RANDOM_ITEMS  = 1200;
	localparam int PHASE_ITEMS   = 100;
	localparam int SETTLE_CYCLES = 10;

	localparam logic [nsl_pkg::CFG_IDX_W-1:0]  REG_UNUSED = 3'd7;
	localparam logic                           MODE_ALLOC = ~nsl_pkg::MODE_POLAR;
	localparam logic [nsl_pkg::CFG_DATA_W-1:0] LIMIT_MAX  = '1;

	localparam logic signed [nsl_pkg::POS_W-1:0] POS_MAX = 16'sh7fff;
	localparam logic signed [nsl_pkg::POS_W-1:0] POS_MIN = 16'sh8000;
	localparam logic signed [nsl_pkg::POS_W-1:0] UNIT    = 16'sd16384;
	localparam logic signed [nsl_pkg::POS_W-1:0] HALF    = 16'sd8192;
	localparam logic signed [nsl_pkg::POS_W-1:0] ZERO    = 16'sd0;
	// angles in 1/128 degree
	localparam logic signed [nsl_pkg::POS_W-1:0] AZ30 = 16'sd3840;
	localparam logic signed [nsl_pkg::POS_W-1:0] EL45 = 16'sd5760;
	localparam logic signed [nsl_pkg::POS_W-1:0] EL60 = 16'sd7680;

	logic                                  clk;
	logic                                  arst_n;
	logic                                  in_valid;
	logic                                  in_stall;
	logic                                  action;
	logic [nsl_pkg::IDX_OUT_W-1:0]         entry_index;
	logic signed [nsl_pkg::POS_W-1:0]      pos_x, pos_y, pos_z;
	logic signed [nsl_pkg::POS_W-1:0]      azimuth, elevation;
	logic signed [nsl_pkg::POS_W-1:0]      lock_x, lock_y, lock_z;
	logic [nsl_pkg::MASK_W-1:0]            excluded_mask;
	logic                                  out_valid;
	logic                                  out_stall;
	logic signed [nsl_pkg::POS_W-1:0]      result_x, result_y, result_z;
	logic                                  did_lock;
	logic [nsl_pkg::IDX_OUT_W-1:0]         chosen_speaker;
	logic                                  cfg_valid;
	logic                                  cfg_ready;
	logic [nsl_pkg::CFG_IDX_W-1:0]         cfg_index;
	logic [nsl_pkg::CFG_DATA_W-1:0]        cfg_data;
	int                                    errors;
	int                                    waiting;
	int                                    cycle_count = 0;
	int                                    calm_in = 0;

	// positions last loaded per entry, used to aim queries and build ties
	logic signed [nsl_pkg::POS_W-1:0] placed_x [SPEAKERS];
	logic signed [nsl_pkg::POS_W-1:0] placed_y [SPEAKERS];
	logic signed [nsl_pkg::POS_W-1:0] placed_z [SPEAKERS];

	nearest_speaker_channel_lock #(
		.MAX_SPEAKERS(SPEAKERS)
	) u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .action(action),
		.entry_index(entry_index), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.azimuth(azimuth), .elevation(elevation),
		.lock_x(lock_x), .lock_y(lock_y), .lock_z(lock_z), .excluded_mask(excluded_mask),
		.out_valid(out_valid), .out_stall(out_stall),
		.result_x(result_x), .result_y(result_y), .result_z(result_z),
		.did_lock(did_lock), .chosen_speaker(chosen_speaker),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	nsl_lock_checker #(
		.SPEAKERS(SPEAKERS)
	) u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .action(action),
		.entry_index(entry_index), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.azimuth(azimuth), .elevation(elevation),
		.lock_x(lock_x), .lock_y(lock_y), .lock_z(lock_z), .excluded_mask(excluded_mask),
		.out_valid(out_valid), .out_stall(out_stall),
		.result_x(result_x), .result_y(result_y), .result_z(result_z),
		.did_lock(did_lock), .chosen_speaker(chosen_speaker),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .waiting(waiting)
	);

	// clock
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// receiver stalls: free runs, mostly short stalls, now and then a long one
	initial begin : result_backpressure
		int free_len;
		int stall_len;
		int r;
		out_stall = 1'b0;
		forever begin
			r = $urandom_range(0, 99);
			free_len = (r < 10) ? $urandom_range(20, 80) : $urandom_range(0, 4);
			r = $urandom_range(0, 99);
			if (r < 85)
				stall_len = $urandom_range(1, 3);
			else if (r < 97)
				stall_len = $urandom_range(4, 12);
			else
				stall_len = $urandom_range(20, 60);
			if (free_len > 0) begin
				out_stall = 1'b0;
				repeat (free_len) @(negedge clk);
			end
			out_stall = 1'b1;
			repeat (stall_len) @(negedge clk);
		end
	end

	// idle cycles before an input beat; occasional runs with none at all
	function automatic int input_gap();
		int r;
		if (calm_in > 0) begin
			calm_in--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 5) begin
			calm_in = $urandom_range(10, 40);
			return 0;
		end
		if (r < 50)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic signed [nsl_pkg::POS_W-1:0] pick_extreme();
		case ($urandom_range(0, 5))
			0: return POS_MIN;
			1: return POS_MAX;
			2: return ZERO;
			3: return -16'sd1;
			4: return UNIT;
			default: return -UNIT;
		endcase
	endfunction

	function automatic logic signed [nsl_pkg::POS_W-1:0] rand_coord();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return pick_extreme();
		if (r < 35)
			return nsl_pkg::POS_W'($urandom);
		return nsl_pkg::POS_W'(int'($urandom_range(0, 32768)) - 16384);
	endfunction

	// common layout angles give many |az| and |el| ties
	function automatic logic signed [nsl_pkg::POS_W-1:0] rand_angle();
		int r;
		int deg;
		r = $urandom_range(0, 99);
		if (r < 10)
			return pick_extreme();
		if (r < 40)
			return nsl_pkg::POS_W'($urandom);
		case ($urandom_range(0, 7))
			0: deg = 0;
			1: deg = 30;
			2: deg = 45;
			3: deg = 60;
			4: deg = 90;
			5: deg = 110;
			6: deg = 135;
			default: deg = 180;
		endcase
		if ($urandom_range(0, 1) != 0)
			deg = -deg;
		return nsl_pkg::POS_W'(deg * 128);
	endfunction

	function automatic logic signed [nsl_pkg::POS_W-1:0] nudge();
		return nsl_pkg::POS_W'(int'($urandom_range(0, 64)) - 32);
	endfunction

	function automatic logic [nsl_pkg::MASK_W-1:0] rand_mask();
		logic [nsl_pkg::MASK_W-1:0] m;
		int r;
		r = $urandom_range(0, 99);
		m = '0;
		if (r < 40)
			m = '0;
		else if (r < 60)
			repeat ($urandom_range(1, 4)) m[$urandom_range(0, nsl_pkg::MASK_W-1)] = 1'b1;
		else if (r < 82)
			m = {$urandom, $urandom};
		else if (r < 90)
			m = '1;
		else
			m = ~(64'd1 << $urandom_range(0, SPEAKERS-1));
		return m;
	endfunction

	function automatic logic [nsl_pkg::CFG_DATA_W-1:0] rand_word40();
		return {8'($urandom), 32'($urandom)};
	endfunction

	function automatic logic [nsl_pkg::CFG_DATA_W-1:0] rand_limit();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return '0;
		if (r < 16)
			return LIMIT_MAX;
		if (r < 22)
			return nsl_pkg::CFG_DATA_W'(1);
		if (r < 40)
			return rand_word40();
		return nsl_pkg::CFG_DATA_W'($urandom) << $urandom_range(0, 8);
	endfunction

	function automatic logic [nsl_pkg::CNT_REG_W-1:0] rand_count();
		case ($urandom_range(0, 7))
			0: return nsl_pkg::CNT_REG_W'(0);
			1: return nsl_pkg::CNT_REG_W'(1);
			2: return nsl_pkg::CNT_REG_W'(SPEAKERS);
			3: return nsl_pkg::CNT_REG_W'(64);
			4: return nsl_pkg::CNT_REG_W'(127);
			5: return nsl_pkg::CNT_REG_W'($urandom_range(1, SPEAKERS-1));
			default: return nsl_pkg::CNT_REG_W'($urandom_range(SPEAKERS+1, 127));
		endcase
	endfunction

	// one input beat: optional gap, then hold until taken
	task automatic send_beat(logic act, logic [nsl_pkg::IDX_OUT_W-1:0] idx,
			logic signed [nsl_pkg::POS_W-1:0] px, py, pz, az, el, lx, ly, lz,
			logic [nsl_pkg::MASK_W-1:0] mask);
		int gap;
		gap = input_gap();
		@(negedge clk);
		while (gap > 0) begin
			in_valid = 1'b0;
			@(negedge clk);
			gap--;
		end
		in_valid = 1'b1;
		action = act;
		entry_index = idx;
		pos_x = px;
		pos_y = py;
		pos_z = pz;
		azimuth = az;
		elevation = el;
		lock_x = lx;
		lock_y = ly;
		lock_z = lz;
		excluded_mask = mask;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic load_speaker(logic [nsl_pkg::IDX_OUT_W-1:0] idx,
			logic signed [nsl_pkg::POS_W-1:0] x, y, z, az, el, lx, ly, lz);
		if (idx < SPEAKERS) begin
			placed_x[idx] = x;
			placed_y[idx] = y;
			placed_z[idx] = z;
		end
		send_beat(nsl_pkg::ACT_LOAD, idx, x, y, z, az, el, lx, ly, lz,
			{$urandom, $urandom});
	endtask

	// query beat; fields a query does not use get random values
	task automatic query(logic signed [nsl_pkg::POS_W-1:0] x, y, z,
			logic [nsl_pkg::MASK_W-1:0] mask);
		send_beat(nsl_pkg::ACT_QUERY, nsl_pkg::IDX_OUT_W'($urandom), x, y, z,
			nsl_pkg::POS_W'($urandom), nsl_pkg::POS_W'($urandom),
			nsl_pkg::POS_W'($urandom), nsl_pkg::POS_W'($urandom),
			nsl_pkg::POS_W'($urandom), mask);
	endtask

	task automatic random_load();
		logic [nsl_pkg::IDX_OUT_W-1:0]     idx;
		logic signed [nsl_pkg::POS_W-1:0]  x, y, z;
		int                                src;
		if ($urandom_range(0, 9) == 0)
			idx = nsl_pkg::IDX_OUT_W'($urandom_range(SPEAKERS, 63));
		else
			idx = nsl_pkg::IDX_OUT_W'($urandom_range(0, SPEAKERS-1));
		if ($urandom_range(0, 99) < 40) begin
			// duplicate position: distance ties settled by angle or index
			src = $urandom_range(0, SPEAKERS-1);
			x = placed_x[src];
			y = placed_y[src];
			z = placed_z[src];
		end else begin
			x = rand_coord();
			y = rand_coord();
			z = rand_coord();
		end
		load_speaker(idx, x, y, z, rand_angle(), rand_angle(), rand_coord(), rand_coord(),
			rand_coord());
	endtask

	task automatic random_query();
		logic signed [nsl_pkg::POS_W-1:0]  x, y, z;
		int                                r;
		int                                src;
		r = $urandom_range(0, 99);
		src = $urandom_range(0, SPEAKERS-1);
		if (r < 40) begin
			x = placed_x[src];
			y = placed_y[src];
			z = placed_z[src];
		end else if (r < 70) begin
			x = placed_x[src] + nudge();
			y = placed_y[src] + nudge();
			z = placed_z[src] + nudge();
		end else begin
			x = rand_coord();
			y = rand_coord();
			z = rand_coord();
		end
		query(x, y, z, rand_mask());
	endtask

	// register writes keep valid high back to back; configure drops it after the last
	task automatic write_reg(logic [nsl_pkg::CFG_IDX_W-1:0] idx,
			logic [nsl_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	// single-bit registers carry random upper bits
	task automatic configure(logic lock, logic mode, logic lim,
			logic [nsl_pkg::CFG_DATA_W-1:0] max_sq, logic [nsl_pkg::CNT_REG_W-1:0] count);
		write_reg(nsl_pkg::REG_LOCK_ENABLE, {(nsl_pkg::CFG_DATA_W-1)'(rand_word40()), lock});
		write_reg(nsl_pkg::REG_DISTANCE_MODE,
			{(nsl_pkg::CFG_DATA_W-1)'(rand_word40()), mode});
		write_reg(nsl_pkg::REG_LIMIT_ENABLE, {(nsl_pkg::CFG_DATA_W-1)'(rand_word40()), lim});
		write_reg(nsl_pkg::REG_MAX_DIST_SQ, max_sq);
		write_reg(nsl_pkg::REG_SPEAKER_COUNT,
			{(nsl_pkg::CFG_DATA_W-nsl_pkg::CNT_REG_W)'(rand_word40()), count});
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// wait for every predicted result, then let the block go quiet
	task automatic drain_results();
		@(negedge clk);
		in_valid = 1'b0;
		while (waiting != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_phase(int p);
		case (p)
			0: configure(1'b1, nsl_pkg::MODE_POLAR, 1'b0, rand_limit(),
				nsl_pkg::CNT_REG_W'(SPEAKERS));
			1: configure(1'b1, MODE_ALLOC, 1'b0, rand_limit(), nsl_pkg::CNT_REG_W'(SPEAKERS));
			2: configure(1'b1, nsl_pkg::MODE_POLAR, 1'b1, rand_limit(),
				nsl_pkg::CNT_REG_W'(SPEAKERS));
			3: configure(1'b1, MODE_ALLOC, 1'b1, LIMIT_MAX, nsl_pkg::CNT_REG_W'(64));
			4: configure(1'b1, nsl_pkg::MODE_POLAR, 1'b1, '0, nsl_pkg::CNT_REG_W'(127));
			5: configure(1'b0, MODE_ALLOC, 1'b1, rand_limit(), nsl_pkg::CNT_REG_W'(SPEAKERS));
			6: configure(1'b1, MODE_ALLOC, 1'b1, rand_limit(), nsl_pkg::CNT_REG_W'(1));
			7: configure(1'b1, nsl_pkg::MODE_POLAR, 1'b0, LIMIT_MAX,
				nsl_pkg::CNT_REG_W'(SPEAKERS-1));
			8: configure(1'b1, nsl_pkg::MODE_POLAR, 1'b1, rand_limit(),
				nsl_pkg::CNT_REG_W'(SPEAKERS+1));
			default: configure($urandom_range(0, 7) != 0, 1'($urandom), 1'($urandom),
				rand_limit(), rand_count());
		endcase
	endtask

	initial begin : stimulus
		int i;
		int p;
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = nsl_pkg::ACT_LOAD;
		entry_index = '0;
		pos_x = '0;
		pos_y = '0;
		pos_z = '0;
		azimuth = '0;
		elevation = '0;
		lock_x = '0;
		lock_y = '0;
		lock_z = '0;
		excluded_mask = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// lock off after reset: the source passes through
		query(POS_MIN, POS_MAX, ZERO, '1);
		// loads past the table end are dropped
		load_speaker(6'd63, POS_MAX, POS_MIN, POS_MAX, POS_MIN, POS_MAX, POS_MIN, POS_MAX,
			POS_MIN);
		load_speaker(6'd32, POS_MIN, POS_MAX, POS_MIN, POS_MAX, POS_MIN, POS_MAX, POS_MIN,
			POS_MAX);
		// three speakers at one spot: -az beats +az, exact tie goes to the lower entry
		load_speaker(6'd0, ZERO, ZERO, UNIT, AZ30, ZERO, 16'sd101, 16'sd102, 16'sd103);
		load_speaker(6'd1, ZERO, ZERO, UNIT, -AZ30, ZERO, 16'sd201, 16'sd202, 16'sd203);
		load_speaker(6'd2, ZERO, ZERO, UNIT, -AZ30, ZERO, 16'sd301, 16'sd302, 16'sd303);
		load_speaker(6'd3, POS_MIN, POS_MIN, POS_MIN, POS_MIN, POS_MIN, POS_MAX, POS_MIN,
			POS_MAX);
		// same spot and az: |el| first, then the sign of el
		load_speaker(6'd4, UNIT, ZERO, ZERO, ZERO, EL45, 16'sd501, 16'sd502, 16'sd503);
		load_speaker(6'd5, UNIT, ZERO, ZERO, ZERO, -EL45, 16'sd601, 16'sd602, 16'sd603);
		load_speaker(6'd6, UNIT, ZERO, ZERO, ZERO, -EL60, 16'sd701, 16'sd702, 16'sd703);
		drain_results();
		write_reg(REG_UNUSED, rand_word40());
		configure(1'b1, nsl_pkg::MODE_POLAR, 1'b0, '0, nsl_pkg::CNT_REG_W'(7));
		query(ZERO, ZERO, UNIT, '0);
		query(ZERO, ZERO, UNIT, 64'h2);
		query(UNIT, ZERO, ZERO, '0);
		query(POS_MIN, POS_MIN, POS_MIN, '0);
		query(POS_MAX, POS_MAX, POS_MAX, '0);
		query(ZERO, ZERO, UNIT, '1);
		drain_results();
		configure(1'b1, MODE_ALLOC, 1'b0, '0, nsl_pkg::CNT_REG_W'(7));
		query(ZERO, HALF, ZERO, '0);
		query(POS_MAX, POS_MIN, ZERO, '0);
		drain_results();
		// zero limit rejects even an exact hit
		configure(1'b1, nsl_pkg::MODE_POLAR, 1'b1, '0, nsl_pkg::CNT_REG_W'(7));
		query(ZERO, ZERO, UNIT, '0);
		drain_results();
		configure(1'b1, nsl_pkg::MODE_POLAR, 1'b1, nsl_pkg::CFG_DATA_W'(1),
			nsl_pkg::CNT_REG_W'(7));
		query(ZERO, ZERO, UNIT, '0);
		query(POS_MAX, POS_MAX, POS_MAX, '0);
		drain_results();
		configure(1'b1, MODE_ALLOC, 1'b1, LIMIT_MAX, nsl_pkg::CNT_REG_W'(7));
		query(POS_MIN, POS_MAX, POS_MIN, '0);
		drain_results();
		// empty scan
		configure(1'b1, nsl_pkg::MODE_POLAR, 1'b0, '0, nsl_pkg::CNT_REG_W'(0));
		query(UNIT, ZERO, ZERO, '0);
		drain_results();
		configure(1'b0, nsl_pkg::MODE_POLAR, 1'b0, '0, nsl_pkg::CNT_REG_W'(7));
		query(UNIT, ZERO, ZERO, '0);
		drain_results();

		// fill every entry before any full-table scan
		for (i = 0; i < SPEAKERS; i++)
			load_speaker(nsl_pkg::IDX_OUT_W'(i), rand_coord(), rand_coord(), rand_coord(),
				rand_angle(), rand_angle(), rand_coord(), rand_coord(), rand_coord());
		drain_results();

		// random phases, each under its own register setting
		for (p = 0; p < RANDOM_ITEMS / PHASE_ITEMS; p++) begin
			set_phase(p);
			for (i = 0; i < PHASE_ITEMS; i++) begin
				if ($urandom_range(0, 3) == 0)
					random_load();
				else
					random_query();
			end
			drain_results();
		end

		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

/* files.f */
sv/nsl_pkg.sv
sv/nsl_ctrl.sv
sv/nsl_dp.sv
sv/nearest_speaker_channel_lock.sv
test/nsl_lock_checker.sv
test/tb_nearest_speaker_channel_lock.sv
